// File: rtl/epa_pkg.sv
`default_nettype none

package epa_pkg;

   // instruction selector codes
   localparam logic [2:0] KIND_ADC16 = 3'd0;
   localparam logic [2:0] KIND_SBC16 = 3'd1;
   localparam logic [2:0] KIND_NEG   = 3'd2;
   localparam logic [2:0] KIND_RRD   = 3'd3;
   localparam logic [2:0] KIND_RLD   = 3'd4;

   // flag bit positions
   localparam int FL_C  = 0;
   localparam int FL_N  = 1;
   localparam int FL_PV = 2;
   localparam int FL_3  = 3;
   localparam int FL_H  = 4;
   localparam int FL_5  = 5;
   localparam int FL_Z  = 6;
   localparam int FL_S  = 7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  acc;
      logic [15:0] pair_hl;
      logic [15:0] operand;
      logic [7:0]  flags_in;
      logic [7:0]  mem_byte;
   } op_type;

   typedef struct packed {
      logic [7:0]  acc_out;
      logic [15:0] pair_out;
      logic [7:0]  mem_out;
      logic [7:0]  flags_out;
   } res_type;

endpackage

`default_nettype wire

// File: rtl/epa_core.sv
`default_nettype none

module epa_core (
   input  wire epa_pkg::op_type  op,
   output epa_pkg::res_type      res
);

   logic        sub;
   logic [15:0] addend;
   logic        cin;
   logic [16:0] sum17;
   logic [12:0] half13;
   logic [15:0] r16;
   logic [7:0]  wide_fl;
   logic [7:0]  neg_a;
   logic [7:0]  neg_fl;
   logic [7:0]  rot_a;
   logic [7:0]  rot_m;
   logic [7:0]  rot_fl;

   // one shared adder: subtract is add of the inverted operand, carries inverted
   assign sub    = (op.kind == epa_pkg::KIND_SBC16);
   assign addend = sub ? ~op.operand : op.operand;
   assign cin    = op.flags_in[epa_pkg::FL_C] ^ sub;
   assign sum17  = {1'b0, op.pair_hl} + {1'b0, addend} + {16'd0, cin};
   assign half13 = {1'b0, op.pair_hl[11:0]} + {1'b0, addend[11:0]} + {12'd0, cin};
   assign r16    = sum17[15:0];

   always_comb begin
      wide_fl              = 8'd0;
      wide_fl[epa_pkg::FL_C]  = sum17[16] ^ sub;
      wide_fl[epa_pkg::FL_N]  = sub;
      wide_fl[epa_pkg::FL_PV] = ~(op.pair_hl[15] ^ addend[15]) & (op.pair_hl[15] ^ r16[15]);
      wide_fl[epa_pkg::FL_3]  = r16[11];
      wide_fl[epa_pkg::FL_H]  = half13[12] ^ sub;
      wide_fl[epa_pkg::FL_5]  = r16[13];
      wide_fl[epa_pkg::FL_Z]  = (r16 == 16'd0);
      wide_fl[epa_pkg::FL_S]  = r16[15];
   end

   assign neg_a = 8'd0 - op.acc;

   always_comb begin
      neg_fl               = 8'd0;
      neg_fl[epa_pkg::FL_C]  = (op.acc != 8'd0);
      neg_fl[epa_pkg::FL_N]  = 1'b1;
      neg_fl[epa_pkg::FL_PV] = (op.acc == 8'h80);
      neg_fl[epa_pkg::FL_3]  = neg_a[3];
      neg_fl[epa_pkg::FL_H]  = (op.acc[3:0] != 4'd0);
      neg_fl[epa_pkg::FL_5]  = neg_a[5];
      neg_fl[epa_pkg::FL_Z]  = (neg_a == 8'd0);
      neg_fl[epa_pkg::FL_S]  = neg_a[7];
   end

   always_comb begin
      if (op.kind == epa_pkg::KIND_RRD) begin
         rot_a = {op.acc[7:4], op.mem_byte[3:0]};
         rot_m = {op.acc[3:0], op.mem_byte[7:4]};
      end else begin
         rot_a = {op.acc[7:4], op.mem_byte[7:4]};
         rot_m = {op.mem_byte[3:0], op.acc[3:0]};
      end
      rot_fl               = 8'd0;
      rot_fl[epa_pkg::FL_C]  = op.flags_in[epa_pkg::FL_C];
      rot_fl[epa_pkg::FL_PV] = ~^rot_a;
      rot_fl[epa_pkg::FL_3]  = rot_a[3];
      rot_fl[epa_pkg::FL_5]  = rot_a[5];
      rot_fl[epa_pkg::FL_Z]  = (rot_a == 8'd0);
      rot_fl[epa_pkg::FL_S]  = rot_a[7];
   end

   always_comb begin
      res.acc_out   = op.acc;
      res.pair_out  = op.pair_hl;
      res.mem_out   = 8'd0;
      res.flags_out = op.flags_in;
      unique case (op.kind) inside
         epa_pkg::KIND_ADC16, epa_pkg::KIND_SBC16: begin
            res.pair_out  = r16;
            res.flags_out = wide_fl;
         end
         epa_pkg::KIND_NEG: begin
            res.acc_out   = neg_a;
            res.flags_out = neg_fl;
         end
         epa_pkg::KIND_RRD, epa_pkg::KIND_RLD: begin
            res.acc_out   = rot_a;
            res.mem_out   = rot_m;
            res.flags_out = rot_fl;
         end
         default: begin
            // undefined selector: acc, pair and flags pass through unchanged, mem_out is zero
            res.acc_out = op.acc;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/ed_prefix_arith_unit.sv
`default_nettype none

// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+--------------------------------------------
// req      | in        | req_valid / req_stall | kind, acc, pair_hl, operand, flags_in, mem_byte
// rsp      | out       | rsp_valid / rsp_stall | acc_out, pair_out, mem_out, flags_out
//
// Two register stages: an operand register, then the result register; the
// whole instruction is evaluated combinationally by epa_core between them.
// A req beat goes from the operand register into the result register, which
// drives rsp_valid and holds the beat while rsp_stall is high; one beat a cycle
// sustained while rsp_stall is low. The 17-bit shared adder is the critical path.
// Synchronous active-high reset empties both stages; payload is not reset.
// rsp_stall holds the result register; the operand stage keeps taking a beat
// until it is also full, then req_stall rises (no combinational path from
// req_valid).

module ed_prefix_arith_unit (
   input  wire         clock,
   input  wire         reset,

   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [2:0]  req_kind,
   input  wire  [7:0]  req_acc,
   input  wire  [15:0] req_pair_hl,
   input  wire  [15:0] req_operand,
   input  wire  [7:0]  req_flags_in,
   input  wire  [7:0]  req_mem_byte,

   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [7:0]  rsp_acc_out,
   output logic [15:0] rsp_pair_out,
   output logic [7:0]  rsp_mem_out,
   output logic [7:0]  rsp_flags_out
);

   logic             op_valid_ff;
   logic             op_valid_in;
   epa_pkg::op_type  op_ff;
   epa_pkg::op_type  op_in;
   logic             res_valid_ff;
   logic             res_valid_in;
   epa_pkg::res_type res_ff;
   epa_pkg::res_type res_calc;
   logic             res_load;
   logic             op_load;

   // result register frees up when empty or drained this cycle
   assign res_load  = !res_valid_ff || !rsp_stall;
   assign op_load   = !op_valid_ff || res_load;
   assign req_stall = !op_load;

   assign op_in = '{kind:     req_kind,
                    acc:      req_acc,
                    pair_hl:  req_pair_hl,
                    operand:  req_operand,
                    flags_in: req_flags_in,
                    mem_byte: req_mem_byte};

   assign op_valid_in  = op_load ? req_valid : op_valid_ff;
   assign res_valid_in = res_load ? op_valid_ff : res_valid_ff;

   epa_core u_core (
      .op  (op_ff),
      .res (res_calc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         op_valid_ff  <= op_valid_in;
         res_valid_ff <= res_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (op_load) begin
         op_ff <= op_in;
      end
      if (res_load) begin
         res_ff <= res_calc;
      end
   end

   assign rsp_valid     = res_valid_ff;
   assign rsp_acc_out   = res_ff.acc_out;
   assign rsp_pair_out  = res_ff.pair_out;
   assign rsp_mem_out   = res_ff.mem_out;
   assign rsp_flags_out = res_ff.flags_out;

   // back-pressure only when both stages hold a beat and the sink stalls
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (op_valid_ff && res_valid_ff && rsp_stall))
      else $error("req_stall raised with a free stage");

   // a held operand with room downstream must reach the result register
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (op_valid_ff && res_load) |=> res_valid_ff)
      else $error("operand beat lost between stages");

   // a pending result that is stalled must not vanish
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (res_valid_ff && rsp_stall) |=> res_valid_ff)
      else $error("stalled result dropped");

   // reset empties the pipe
   a_reset: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("pipe not empty after reset");

endmodule

`default_nettype wire

// File: tb/ed_prefix_arith_unit_test.sv
`timescale 1ns / 100ps

module ed_prefix_arith_unit_test;

   localparam int unsigned RUN_ITEMS   = 1700;   // random beats with a real opcode
   localparam int unsigned QUIET_TAIL  = 300;    // closing beats with no idling at all
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_WAIT  = 8;      // two-stage pipe, plus margin
   localparam int unsigned REPORT_MAX  = 10;

   // selector codes with no instruction behind them: the unit passes them through
   localparam logic [2:0] KIND_SPARE5 = 3'd5;
   localparam logic [2:0] KIND_SPARE6 = 3'd6;
   localparam logic [2:0] KIND_SPARE7 = 3'd7;

   typedef struct {
      epa_pkg::op_type  op;
      bit               known;    // expected beat typed in below rather than predicted
      epa_pkg::res_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind = '0;
   logic [7:0]  req_acc = '0;
   logic [15:0] req_pair_hl = '0;
   logic [15:0] req_operand = '0;
   logic [7:0]  req_flags_in = '0;
   logic [7:0]  req_mem_byte = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_acc_out;
   logic [15:0] rsp_pair_out;
   logic [7:0]  rsp_mem_out;
   logic [7:0]  rsp_flags_out;

   // what the monitor pushes when the current req beat is taken
   bit               cur_known = 1'b0;
   epa_pkg::res_type cur_want = '0;

   bit          quiet = 1'b0;        // last stretch: no gaps, no stalls
   int unsigned stall_left = 0;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;

   epa_pkg::res_type pending_results[$];  // results owed by the unit, oldest first
   epa_pkg::res_type head_res;
   dir_row_type      dir_rows[$];

   ed_prefix_arith_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_acc       (req_acc),
      .req_pair_hl   (req_pair_hl),
      .req_operand   (req_operand),
      .req_flags_in  (req_flags_in),
      .req_mem_byte  (req_mem_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_acc_out   (rsp_acc_out),
      .rsp_pair_out  (rsp_pair_out),
      .rsp_mem_out   (rsp_mem_out),
      .rsp_flags_out (rsp_flags_out)
   );

   always #6 clock = ~clock;

   // Independent model of the ED-prefix arithmetic.
   function automatic epa_pkg::res_type ed_arith_predict(input epa_pkg::op_type o);
      epa_pkg::res_type r;
      logic             cin;
      logic [16:0]      wide;
      logic [12:0]      low12;
      logic             ovf;
      cin = o.flags_in[epa_pkg::FL_C];
      r.acc_out   = o.acc;
      r.pair_out  = o.pair_hl;
      r.mem_out   = '0;
      r.flags_out = o.flags_in;
      case (o.kind) inside
         epa_pkg::KIND_ADC16, epa_pkg::KIND_SBC16: begin
            if (o.kind == epa_pkg::KIND_ADC16) begin
               wide  = {1'b0, o.pair_hl} + {1'b0, o.operand} + 17'(cin);
               low12 = {1'b0, o.pair_hl[11:0]} + {1'b0, o.operand[11:0]} + 13'(cin);
               // same-sign operands, result sign flipped
               ovf   = (o.pair_hl[15] == o.operand[15]) && (wide[15] != o.pair_hl[15]);
            end else begin
               wide  = {1'b0, o.pair_hl} - {1'b0, o.operand} - 17'(cin);
               low12 = {1'b0, o.pair_hl[11:0]} - {1'b0, o.operand[11:0]} - 13'(cin);
               ovf   = (o.pair_hl[15] != o.operand[15]) && (wide[15] != o.pair_hl[15]);
            end
            r.pair_out = wide[15:0];
            r.flags_out = '0;
            r.flags_out[epa_pkg::FL_S]  = wide[15];
            r.flags_out[epa_pkg::FL_Z]  = (wide[15:0] == 16'h0000);
            r.flags_out[epa_pkg::FL_5]  = wide[13];
            r.flags_out[epa_pkg::FL_H]  = low12[12];
            r.flags_out[epa_pkg::FL_3]  = wide[11];
            r.flags_out[epa_pkg::FL_PV] = ovf;
            r.flags_out[epa_pkg::FL_N]  = (o.kind == epa_pkg::KIND_SBC16);
            r.flags_out[epa_pkg::FL_C]  = wide[16];
         end
         epa_pkg::KIND_NEG: begin
            r.acc_out = 8'h00 - o.acc;
            r.flags_out = '0;
            r.flags_out[epa_pkg::FL_S]  = r.acc_out[7];
            r.flags_out[epa_pkg::FL_Z]  = (r.acc_out == 8'h00);
            r.flags_out[epa_pkg::FL_5]  = r.acc_out[5];
            r.flags_out[epa_pkg::FL_H]  = (o.acc[3:0] != 4'h0);
            r.flags_out[epa_pkg::FL_3]  = r.acc_out[3];
            r.flags_out[epa_pkg::FL_PV] = (o.acc == 8'h80);
            r.flags_out[epa_pkg::FL_N]  = 1'b1;
            r.flags_out[epa_pkg::FL_C]  = (o.acc != 8'h00);
         end
         epa_pkg::KIND_RRD, epa_pkg::KIND_RLD: begin
            if (o.kind == epa_pkg::KIND_RRD) begin
               r.mem_out = {o.acc[3:0], o.mem_byte[7:4]};
               r.acc_out = {o.acc[7:4], o.mem_byte[3:0]};
            end else begin
               r.mem_out = {o.mem_byte[3:0], o.acc[3:0]};
               r.acc_out = {o.acc[7:4], o.mem_byte[7:4]};
            end
            r.flags_out = '0;
            r.flags_out[epa_pkg::FL_S]  = r.acc_out[7];
            r.flags_out[epa_pkg::FL_Z]  = (r.acc_out == 8'h00);
            r.flags_out[epa_pkg::FL_5]  = r.acc_out[5];
            r.flags_out[epa_pkg::FL_3]  = r.acc_out[3];
            r.flags_out[epa_pkg::FL_PV] = ~^r.acc_out;   // even parity
            r.flags_out[epa_pkg::FL_C]  = cin;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Random beat; corners (00/7F/80/FF style values, HL,HL) get extra weight.
   function automatic epa_pkg::op_type pick_op();
      epa_pkg::op_type o;
      if ($urandom_range(19) == 0)
         o.kind = 3'($urandom_range(7, 5));
      else
         o.kind = 3'($urandom_range(4, 0));
      o.acc      = 8'($urandom);
      o.pair_hl  = 16'($urandom);
      o.operand  = 16'($urandom);
      o.flags_in = 8'($urandom);
      o.mem_byte = 8'($urandom);
      if ($urandom_range(7) == 0)
         o.acc = {o.acc[7], {7{o.acc[6]}}};
      if ($urandom_range(7) == 0)
         o.pair_hl = {o.pair_hl[15], {15{o.pair_hl[14]}}};
      if ($urandom_range(7) == 0)
         o.operand = {o.operand[15], {15{o.operand[14]}}};
      if ($urandom_range(9) == 0)
         o.operand = o.pair_hl;
      return o;
   endfunction

   task automatic add_row(input logic [2:0] kind, input logic [7:0] acc,
                          input logic [15:0] hl, input logic [15:0] rr,
                          input logic [7:0] fl, input logic [7:0] mem,
                          input bit known, input logic [7:0] w_acc,
                          input logic [15:0] w_pair, input logic [7:0] w_mem,
                          input logic [7:0] w_flags);
      dir_row_type row;
      row.op    = '{kind, acc, hl, rr, fl, mem};
      row.known = known;
      row.want  = '{w_acc, w_pair, w_mem, w_flags};
      dir_rows.push_back(row);
   endtask

   // Present one req beat at the falling edge, optionally after a gap, and
   // hold it until the unit takes it.
   task automatic send_beat(input epa_pkg::op_type o, input bit known,
                            input epa_pkg::res_type want);
      int unsigned gap;
      if (!quiet && $urandom_range(5) == 0) begin
         gap = $urandom_range(16, 1);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    = 1'b1;
      req_kind     = o.kind;
      req_acc      = o.acc;
      req_pair_hl  = o.pair_hl;
      req_operand  = o.operand;
      req_flags_in = o.flags_in;
      req_mem_byte = o.mem_byte;
      cur_known    = known;
      cur_want     = want;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
   endtask

   // Receiver back-pressure: random bursts of stalled cycles, none in the tail.
   always @(negedge clock) begin
      if (quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(15, 0);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // Scoreboard. The rsp side is checked before the req side is booked, so a
   // beat taken on this edge can never be matched against itself.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("rsp beat with nothing owed: acc %h hl %h mem %h f %h",
                           rsp_acc_out, rsp_pair_out, rsp_mem_out, rsp_flags_out);
            end else begin
               head_res = pending_results.pop_front();
               if (rsp_acc_out !== head_res.acc_out || rsp_pair_out !== head_res.pair_out ||
                   rsp_mem_out !== head_res.mem_out ||
                   rsp_flags_out !== head_res.flags_out) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX)
                     $display("mismatch: exp acc %h hl %h mem %h f %h, %s",
                              head_res.acc_out, head_res.pair_out, head_res.mem_out,
                              head_res.flags_out,
                              $sformatf("got acc %h hl %h mem %h f %h",
                                        rsp_acc_out, rsp_pair_out,
                                        rsp_mem_out, rsp_flags_out));
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (cur_known)
               pending_results.push_back(cur_want);
            else
               pending_results.push_back(ed_arith_predict('{req_kind, req_acc, req_pair_hl,
                                                            req_operand, req_flags_in,
                                                            req_mem_byte}));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int unsigned     sent;
      epa_pkg::op_type o;

      // Directed beats: corners of each instruction and the pass-through codes.
      //      kind, acc, hl, rr, f, mem
      //      known, want acc/hl/mem/f
      add_row(epa_pkg::KIND_ADC16, 8'h12, 16'h0000, 16'h0000, 8'h00, 8'h00,
              1, 8'h12, 16'h0000, 8'h00, 8'h40);
      add_row(epa_pkg::KIND_ADC16, 8'h00, 16'hFFFF, 16'h0001, 8'h00, 8'hFF,
              1, 8'h00, 16'h0000, 8'h00, 8'h51);
      add_row(epa_pkg::KIND_ADC16, 8'h00, 16'h7FFF, 16'h0000, 8'h01, 8'h00,
              0, '0, '0, '0, '0);
      add_row(epa_pkg::KIND_ADC16, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'h00,
              0, '0, '0, '0, '0);
      add_row(epa_pkg::KIND_ADC16, 8'h00, 16'h8000, 16'h8000, 8'h00, 8'h00,
              0, '0, '0, '0, '0);
      add_row(epa_pkg::KIND_SBC16, 8'h34, 16'h0000, 16'h0000, 8'h00, 8'h00,
              1, 8'h34, 16'h0000, 8'h00, 8'h42);
      add_row(epa_pkg::KIND_SBC16, 8'h00, 16'h0000, 16'h0000, 8'h01, 8'h00,
              0, '0, '0, '0, '0);
      add_row(epa_pkg::KIND_SBC16, 8'h00, 16'h8000, 16'h0001, 8'h00, 8'h00,
              0, '0, '0, '0, '0);
      add_row(epa_pkg::KIND_SBC16, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
              0, '0, '0, '0, '0);
      add_row(epa_pkg::KIND_SBC16, 8'h00, 16'h1000, 16'h0001, 8'h00, 8'h00,
              0, '0, '0, '0, '0);
      add_row(epa_pkg::KIND_NEG,   8'h00, 16'hABCD, 16'hFFFF, 8'hFF, 8'hFF,
              1, 8'h00, 16'hABCD, 8'h00, 8'h42);
      add_row(epa_pkg::KIND_NEG,   8'h80, 16'h1234, 16'h0000, 8'h00, 8'h00,
              1, 8'h80, 16'h1234, 8'h00, 8'h87);
      add_row(epa_pkg::KIND_NEG,   8'h01, 16'h0000, 16'h0000, 8'h00, 8'h00,
              0, '0, '0, '0, '0);
      add_row(epa_pkg::KIND_NEG,   8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
              0, '0, '0, '0, '0);
      add_row(epa_pkg::KIND_RRD,   8'h00, 16'h4000, 16'h0000, 8'h00, 8'h00,
              1, 8'h00, 16'h4000, 8'h00, 8'h44);
      add_row(epa_pkg::KIND_RRD,   8'hFF, 16'hFFFF, 16'hFFFF, 8'h01, 8'hFF,
              0, '0, '0, '0, '0);
      add_row(epa_pkg::KIND_RRD,   8'hA5, 16'h0102, 16'h0000, 8'h00, 8'h3C,
              0, '0, '0, '0, '0);
      add_row(epa_pkg::KIND_RLD,   8'h00, 16'h8001, 16'h0000, 8'h01, 8'h00,
              1, 8'h00, 16'h8001, 8'h00, 8'h45);
      add_row(epa_pkg::KIND_RLD,   8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
              0, '0, '0, '0, '0);
      add_row(epa_pkg::KIND_RLD,   8'h5A, 16'h2222, 16'h0000, 8'h00, 8'hC3,
              0, '0, '0, '0, '0);
      add_row(KIND_SPARE5,         8'hAA, 16'h5555, 16'hFFFF, 8'hFF, 8'hFF,
              1, 8'hAA, 16'h5555, 8'h00, 8'hFF);
      add_row(KIND_SPARE6,         8'h55, 16'hAAAA, 16'h0000, 8'h5A, 8'h81,
              1, 8'h55, 16'hAAAA, 8'h00, 8'h5A);
      add_row(KIND_SPARE7,         8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00,
              1, 8'h00, 16'h0000, 8'h00, 8'h00);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i])
         send_beat(dir_rows[i].op, dir_rows[i].known, dir_rows[i].want);

      // Random phase; pass-through codes are mixed in but not counted.
      sent = 0;
      while (sent < RUN_ITEMS) begin
         quiet = (sent >= RUN_ITEMS - QUIET_TAIL);
         o = pick_op();
         send_beat(o, 1'b0, '0);
         if (o.kind <= epa_pkg::KIND_RLD)
            sent++;
      end
      req_valid = 1'b0;

      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: filelist.f
rtl/epa_pkg.sv
rtl/epa_core.sv
rtl/ed_prefix_arith_unit.sv
tb/ed_prefix_arith_unit_test.sv
